### sv/i2cbe_pkg.sv
package i2cbe_pkg;

  // bus command codes
  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_WRITE = 3'd2,
    OP_WAIT  = 3'd3,
    OP_READ  = 3'd4,
    OP_ACK   = 3'd5,
    OP_NACK  = 3'd6
  } op_t;

  // step codes, the meaning of steps one to four depends on the command
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_STEP1 = 3'd1,
    PH_STEP2 = 3'd2,
    PH_STEP3 = 3'd3,
    PH_STEP4 = 3'd4
  } phase_t;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'd1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] PHASE_TICKS_RST = 16'd1;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd200;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    phase_t      phase;
    op_t         op;
    logic [3:0]  bit_count;
    logic [7:0]  shift_reg;
    logic [15:0] tick_count;
    logic [7:0]  poll_count;
    logic        scl_level;
    logic        sda_level;
    logic        ack_error;
    logic [7:0]  rd_hold;
  } state_t;

  localparam state_t ST_RESET = '{
    phase:      PH_IDLE,
    op:         OP_START,
    bit_count:  4'd0,
    shift_reg:  8'd0,
    tick_count: 16'd0,
    poll_count: 8'd0,
    scl_level:  1'b1,
    sda_level:  1'b1,
    ack_error:  1'b0,
    rd_hold:    8'd0
  };

endpackage

### sv/i2c_master_bit_engine_core.sv
// i2c master bit engine: each accepted input transaction is one timing tick that may carry a
// command (start, stop, write byte, wait ack, read byte, send ack, send nack) plus the sampled
// sda level, and yields exactly one result transaction with the scl/sda drives after that tick,
// busy, a done strobe, the last read byte and the missing-ack flag. every bus step but the
// ack poll holds for phase_ticks ticks (zero acts as one); wait-ack polls sda once per tick
// and after more than ack_timeout_limit high polls runs a stop sequence and raises
// ack_missing. commands offered while busy, and function code seven, are dropped. one tick
// is taken every clock cycle while in_stall is low; a tick passes an input register and one
// combinational step into the output register. sda/scl are open-drain style: 1 releases.
// configuration writes are always ready and must only be issued while the engine is idle.
module i2c_master_bit_engine_core (
  input  logic                             clk,
  input  logic                             rst,
  // tick input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             cmd_valid,
  input  logic [2:0]                       func,
  input  logic [7:0]                       wr_byte,
  input  logic                             sda_in,
  // result output channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             scl_out,
  output logic                             sda_out,
  output logic                             busy_res,
  output logic                             cmd_done,
  output logic [7:0]                       rd_byte,
  output logic                             ack_missing,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [i2cbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [i2cbe_pkg::CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [15:0] phase_ticks;
  logic [7:0]  ack_timeout_limit;

  // input register stage
  logic        s1_valid;
  logic        s1_cmd_valid;
  logic [2:0]  s1_func;
  logic [7:0]  s1_wr_byte;
  logic        s1_sda_in;
  logic        s1_adv;

  // engine state
  i2cbe_pkg::state_t st;
  i2cbe_pkg::state_t st_next;
  logic              step_done;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks       <= i2cbe_pkg::PHASE_TICKS_RST;
      ack_timeout_limit <= i2cbe_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == i2cbe_pkg::CFG_PHASE_TICKS) phase_ticks <= cfg_data[15:0];
      if (cfg_index == i2cbe_pkg::CFG_ACK_TIMEOUT) ack_timeout_limit <= cfg_data[7:0];
    end
  end

  // the tick in the input register moves on whenever the output register is empty
  // or its result is being taken in this cycle
  assign s1_adv   = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  // payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_cmd_valid <= cmd_valid;
      s1_func      <= func;
      s1_wr_byte   <= wr_byte;
      s1_sda_in    <= sda_in;
    end
  end

  // one tick of the bus sequencer
  i2cbe_step u_step (
    .st                (st),
    .cmd_valid         (s1_cmd_valid),
    .func              (s1_func),
    .wr_byte           (s1_wr_byte),
    .sda_in            (s1_sda_in),
    .phase_ticks       (phase_ticks),
    .ack_timeout_limit (ack_timeout_limit),
    .st_next           (st_next),
    .done              (step_done)
  );

  // state advances only when the tick's result is written to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= i2cbe_pkg::ST_RESET;
    end else if (s1_valid && s1_adv) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result register, holds while stalled
  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      scl_out     <= st_next.scl_level;
      sda_out     <= st_next.sda_level;
      busy_res    <= (st_next.phase != i2cbe_pkg::PH_IDLE);
      cmd_done    <= step_done;
      rd_byte     <= st_next.rd_hold;
      ack_missing <= st_next.ack_error;
    end
  end

endmodule

### sv/i2cbe_step.sv
module i2cbe_step (
  input  i2cbe_pkg::state_t st,
  input  logic              cmd_valid,
  input  logic [2:0]        func,
  input  logic [7:0]        wr_byte,
  input  logic              sda_in,
  input  logic [15:0]       phase_ticks,
  input  logic [7:0]        ack_timeout_limit,
  output i2cbe_pkg::state_t st_next,
  output logic              done
);

  // enter a new step: clear the step timer and change at most one line
  function automatic i2cbe_pkg::state_t enter_step(i2cbe_pkg::state_t s, logic [2:0] ph);
    i2cbe_pkg::state_t r;
    r = s;
    r.phase = i2cbe_pkg::phase_t'(ph);
    r.tick_count = '0;
    case (s.op)
      i2cbe_pkg::OP_START: begin
        if (ph == i2cbe_pkg::PH_STEP1) r.sda_level = 1'b1;
        else if (ph == i2cbe_pkg::PH_STEP2) r.scl_level = 1'b1;
        else if (ph == i2cbe_pkg::PH_STEP3) r.sda_level = 1'b0;
        else r.scl_level = 1'b0;
      end
      i2cbe_pkg::OP_STOP: begin
        if (ph == i2cbe_pkg::PH_STEP1) r.scl_level = 1'b0;
        else if (ph == i2cbe_pkg::PH_STEP2) r.sda_level = 1'b0;
        else if (ph == i2cbe_pkg::PH_STEP3) r.scl_level = 1'b1;
        else r.sda_level = 1'b1;
      end
      i2cbe_pkg::OP_WRITE: begin
        if (ph == i2cbe_pkg::PH_STEP2) begin
          r.sda_level = s.shift_reg[7];
          r.shift_reg = {s.shift_reg[6:0], 1'b0};
        end else if (ph == i2cbe_pkg::PH_STEP3) begin
          r.scl_level = 1'b1;
        end else begin
          r.scl_level = 1'b0;
        end
      end
      i2cbe_pkg::OP_WAIT: begin
        if (ph == i2cbe_pkg::PH_STEP1) r.sda_level = 1'b1;
        else if (ph == i2cbe_pkg::PH_STEP2) r.scl_level = 1'b1;
        else if (ph == i2cbe_pkg::PH_STEP4) r.scl_level = 1'b0;
      end
      i2cbe_pkg::OP_READ: begin
        if (ph == i2cbe_pkg::PH_STEP1) r.sda_level = 1'b1;
        else if (ph == i2cbe_pkg::PH_STEP3) r.scl_level = 1'b1;
        else r.scl_level = 1'b0;
      end
      default: begin
        if (ph == i2cbe_pkg::PH_STEP1) r.scl_level = 1'b0;
        else if (ph == i2cbe_pkg::PH_STEP2) r.sda_level = (s.op == i2cbe_pkg::OP_NACK);
        else if (ph == i2cbe_pkg::PH_STEP3) r.scl_level = 1'b1;
        else r.scl_level = 1'b0;
      end
    endcase
    return r;
  endfunction

  logic [15:0] limit;
  logic [15:0] tick_inc;
  logic [3:0]  bit_inc;
  i2cbe_pkg::state_t nx;

  assign limit    = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
  assign tick_inc = st.tick_count + 16'd1;
  assign bit_inc  = st.bit_count + 4'd1;

  always_comb begin
    nx   = st;
    done = 1'b0;
    if (st.phase == i2cbe_pkg::PH_IDLE) begin
      if (cmd_valid && func <= 3'(i2cbe_pkg::OP_NACK)) begin
        nx.op         = i2cbe_pkg::op_t'(func);
        nx.bit_count  = '0;
        nx.poll_count = '0;
        nx.shift_reg  = (func == 3'(i2cbe_pkg::OP_WRITE)) ? wr_byte : 8'd0;
        if (func == 3'(i2cbe_pkg::OP_WAIT)) nx.ack_error = 1'b0;
        nx = enter_step(nx, i2cbe_pkg::PH_STEP1);
      end
    end else if (st.op == i2cbe_pkg::OP_WAIT && st.phase == i2cbe_pkg::PH_STEP3) begin
      // ack poll, one sample per tick
      if (!sda_in) begin
        nx = enter_step(nx, i2cbe_pkg::PH_STEP4);
      end else if (st.poll_count >= ack_timeout_limit) begin
        nx.ack_error = 1'b1;
        nx.op        = i2cbe_pkg::OP_STOP;
        nx = enter_step(nx, i2cbe_pkg::PH_STEP1);
      end else begin
        nx.poll_count = st.poll_count + 8'd1;
      end
    end else begin
      nx.tick_count = tick_inc;
      if (tick_inc >= limit) begin
        if (st.op == i2cbe_pkg::OP_WRITE && st.phase == i2cbe_pkg::PH_STEP3) begin
          nx.bit_count = bit_inc;
          nx = enter_step(nx, (bit_inc < i2cbe_pkg::BITS_PER_BYTE) ?
                              i2cbe_pkg::PH_STEP1 : i2cbe_pkg::PH_STEP4);
        end else if (st.op == i2cbe_pkg::OP_READ && st.phase == i2cbe_pkg::PH_STEP3) begin
          nx.shift_reg = {st.shift_reg[6:0], sda_in};
          nx.bit_count = bit_inc;
          nx = enter_step(nx, (bit_inc < i2cbe_pkg::BITS_PER_BYTE) ?
                              i2cbe_pkg::PH_STEP2 : i2cbe_pkg::PH_STEP4);
        end else if (st.phase < i2cbe_pkg::PH_STEP4) begin
          nx = enter_step(nx, st.phase + 3'd1);
        end else begin
          if (st.op == i2cbe_pkg::OP_READ) nx.rd_hold = st.shift_reg;
          nx.phase      = i2cbe_pkg::PH_IDLE;
          nx.tick_count = '0;
          done          = 1'b1;
        end
      end
    end
  end

  assign st_next = nx;

endmodule

### sv/i2cbe_checker.sv
module i2cbe_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             cmd_valid,
  input logic [2:0]                       func,
  input logic [7:0]                       wr_byte,
  input logic                             sda_in,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             scl_out,
  input logic                             sda_out,
  input logic                             busy_res,
  input logic                             cmd_done,
  input logic [7:0]                       rd_byte,
  input logic                             ack_missing,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [i2cbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [i2cbe_pkg::CFG_DATA_W-1:0] cfg_data
);

  // input only backs up behind a stalled result
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // engine is idle on the tick a command finishes
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && cmd_done) |-> !busy_res)
    else $error("cmd_done with busy set");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(scl_out) && $stable(sda_out)
      && $stable(busy_res) && $stable(cmd_done) && $stable(rd_byte) && $stable(ack_missing)))
    else $error("stalled result changed");

endmodule

bind i2c_master_bit_engine_core i2cbe_checker u_i2cbe_checker (.*);

### sim/i2cbe_bus_checker.sv
`timescale 1ns / 100ps

module i2cbe_bus_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic                             cmd_valid,
  input  logic [2:0]                       func,
  input  logic [7:0]                       wr_byte,
  input  logic                             sda_in,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic                             scl_out,
  input  logic                             sda_out,
  input  logic                             busy_res,
  input  logic                             cmd_done,
  input  logic [7:0]                       rd_byte,
  input  logic                             ack_missing,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [i2cbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [i2cbe_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               mismatch_count,
  output int                               results_pending,
  output logic                             engine_busy
);

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rd;
    logic       ack_miss;
  } line_levels_t;

  // own copy of the engine
  logic [2:0]       step;
  i2cbe_pkg::op_t   op;
  logic [3:0]       bit_cnt;
  logic [7:0]       shreg;
  logic [15:0]      tick_cnt;
  logic [7:0]       poll_cnt;
  logic             scl_lvl;
  logic             sda_lvl;
  logic             ack_err;
  logic [7:0]       rd_hold;
  logic [15:0]      ticks_per_step;
  logic [7:0]       ack_limit;

  line_levels_t line_expect_q[$];

  function automatic void enter_bus_step(input logic [2:0] s);
    step = s;
    tick_cnt = '0;
    case (op)
      i2cbe_pkg::OP_START: begin
        if (s == i2cbe_pkg::PH_STEP1) sda_lvl = 1'b1;
        else if (s == i2cbe_pkg::PH_STEP2) scl_lvl = 1'b1;
        else if (s == i2cbe_pkg::PH_STEP3) sda_lvl = 1'b0;
        else scl_lvl = 1'b0;
      end
      i2cbe_pkg::OP_STOP: begin
        if (s == i2cbe_pkg::PH_STEP1) scl_lvl = 1'b0;
        else if (s == i2cbe_pkg::PH_STEP2) sda_lvl = 1'b0;
        else if (s == i2cbe_pkg::PH_STEP3) scl_lvl = 1'b1;
        else sda_lvl = 1'b1;
      end
      i2cbe_pkg::OP_WRITE: begin
        if (s == i2cbe_pkg::PH_STEP2) begin
          sda_lvl = shreg[7];
          shreg = {shreg[6:0], 1'b0};
        end else if (s == i2cbe_pkg::PH_STEP3) begin
          scl_lvl = 1'b1;
        end else begin
          scl_lvl = 1'b0;
        end
      end
      i2cbe_pkg::OP_WAIT: begin
        if (s == i2cbe_pkg::PH_STEP1) sda_lvl = 1'b1;
        else if (s == i2cbe_pkg::PH_STEP2) scl_lvl = 1'b1;
        else if (s == i2cbe_pkg::PH_STEP4) scl_lvl = 1'b0;
      end
      i2cbe_pkg::OP_READ: begin
        if (s == i2cbe_pkg::PH_STEP1) sda_lvl = 1'b1;
        else if (s == i2cbe_pkg::PH_STEP3) scl_lvl = 1'b1;
        else scl_lvl = 1'b0;
      end
      default: begin
        if (s == i2cbe_pkg::PH_STEP1) scl_lvl = 1'b0;
        else if (s == i2cbe_pkg::PH_STEP2) sda_lvl = (op == i2cbe_pkg::OP_NACK);
        else if (s == i2cbe_pkg::PH_STEP3) scl_lvl = 1'b1;
        else scl_lvl = 1'b0;
      end
    endcase
  endfunction

  // hold of the current step has run out; returns 1 when the command is over
  function automatic logic close_bus_step(input logic s_in);
    logic over;
    over = 1'b0;
    if (op == i2cbe_pkg::OP_WRITE && step == i2cbe_pkg::PH_STEP3) begin
      bit_cnt = bit_cnt + 4'd1;
      enter_bus_step(bit_cnt < i2cbe_pkg::BITS_PER_BYTE ? i2cbe_pkg::PH_STEP1
                                                         : i2cbe_pkg::PH_STEP4);
    end else if (op == i2cbe_pkg::OP_READ && step == i2cbe_pkg::PH_STEP3) begin
      shreg = {shreg[6:0], s_in};
      bit_cnt = bit_cnt + 4'd1;
      enter_bus_step(bit_cnt < i2cbe_pkg::BITS_PER_BYTE ? i2cbe_pkg::PH_STEP2
                                                         : i2cbe_pkg::PH_STEP4);
    end else if (step < i2cbe_pkg::PH_STEP4) begin
      enter_bus_step(step + 3'd1);
    end else begin
      if (op == i2cbe_pkg::OP_READ) rd_hold = shreg;
      step = i2cbe_pkg::PH_IDLE;
      tick_cnt = '0;
      over = 1'b1;
    end
    return over;
  endfunction

  function automatic line_levels_t advance_bus_tick(input logic cv, input logic [2:0] f,
                                                    input logic [7:0] wb, input logic s);
    line_levels_t r;
    logic [15:0] hold;
    logic done;
    hold = (ticks_per_step == '0) ? 16'd1 : ticks_per_step;
    done = 1'b0;
    if (step == i2cbe_pkg::PH_IDLE) begin
      if (cv && f <= i2cbe_pkg::OP_NACK) begin
        op = i2cbe_pkg::op_t'(f);
        bit_cnt = '0;
        poll_cnt = '0;
        shreg = (op == i2cbe_pkg::OP_WRITE) ? wb : 8'd0;
        if (op == i2cbe_pkg::OP_WAIT) ack_err = 1'b0;
        enter_bus_step(i2cbe_pkg::PH_STEP1);
      end
    end else if (op == i2cbe_pkg::OP_WAIT && step == i2cbe_pkg::PH_STEP3) begin
      if (!s) begin
        enter_bus_step(i2cbe_pkg::PH_STEP4);
      end else if (poll_cnt >= ack_limit) begin
        ack_err = 1'b1;
        op = i2cbe_pkg::OP_STOP;
        enter_bus_step(i2cbe_pkg::PH_STEP1);
      end else begin
        poll_cnt = poll_cnt + 8'd1;
      end
    end else begin
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= hold) done = close_bus_step(s);
    end
    r.scl = scl_lvl;
    r.sda = sda_lvl;
    r.busy = (step != i2cbe_pkg::PH_IDLE);
    r.done = done;
    r.rd = rd_hold;
    r.ack_miss = ack_err;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h actual %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    line_levels_t want;
    if (rst) begin
      step = i2cbe_pkg::PH_IDLE;
      op = i2cbe_pkg::OP_START;
      bit_cnt = '0;
      shreg = '0;
      tick_cnt = '0;
      poll_cnt = '0;
      scl_lvl = 1'b1;
      sda_lvl = 1'b1;
      ack_err = 1'b0;
      rd_hold = '0;
      ticks_per_step = i2cbe_pkg::PHASE_TICKS_RST;
      ack_limit = i2cbe_pkg::ACK_TIMEOUT_RST;
      line_expect_q.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          i2cbe_pkg::CFG_PHASE_TICKS: ticks_per_step = cfg_data;
          i2cbe_pkg::CFG_ACK_TIMEOUT: ack_limit = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (line_expect_q.size() == 0) begin
          $error("result transaction with no tick outstanding");
          mismatch_count++;
        end else begin
          want = line_expect_q.pop_front();
          check_field("scl_out", want.scl, scl_out);
          check_field("sda_out", want.sda, sda_out);
          check_field("busy_res", want.busy, busy_res);
          check_field("cmd_done", want.done, cmd_done);
          check_field("rd_byte", want.rd, rd_byte);
          check_field("ack_missing", want.ack_miss, ack_missing);
        end
      end
      if (in_valid && !in_stall)
        line_expect_q.push_back(advance_bus_tick(cmd_valid, func, wr_byte, sda_in));
    end
    results_pending = line_expect_q.size();
    engine_busy = (step != i2cbe_pkg::PH_IDLE);
  end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;

  // no transaction on any channel for this long means the run is stuck
  localparam int QUIET_LIMIT    = 4000;
  // one long receiver hold-off so the engine backs up into its input
  localparam int SQUEEZE_CYCLES = 400;
  // number of random settings the rest of the tick budget is spread over
  localparam int NUM_SETTINGS   = 6;
  // total tick transactions aimed for over the whole run
  localparam int ITEMS_TOTAL    = 1150;
  // function code with no command behind it
  localparam logic [2:0] FUNC_UNUSED = 3'd7;

  // how the sampled sda line behaves during one command
  typedef enum {SDA_COIN, SDA_HIGH, SDA_LOW, SDA_SLOW_ACK} sda_drive_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // tick channel
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       cmd_valid = 1'b0;
  logic [2:0] func = i2cbe_pkg::OP_START;
  logic [7:0] wr_byte = 8'd0;
  logic       sda_in = 1'b1;

  // result channel
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       cmd_done;
  logic [7:0] rd_byte;
  logic       ack_missing;

  // register write channel
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [i2cbe_pkg::CFG_IDX_W-1:0]  cfg_index = i2cbe_pkg::CFG_PHASE_TICKS;
  logic [i2cbe_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // from the checker
  int   mismatch_count;
  int   results_pending;
  logic engine_busy;

  // sender bookkeeping
  int   burst_left = 0;
  int   ticks_sent = 0;
  int   tick_limit = 32'h7fff_ffff;
  logic squeeze_req = 1'b0;

  i2c_master_bit_engine_core DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd_valid  (cmd_valid),
    .func       (func),
    .wr_byte    (wr_byte),
    .sda_in     (sda_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .scl_out    (scl_out),
    .sda_out    (sda_out),
    .busy_res   (busy_res),
    .cmd_done   (cmd_done),
    .rd_byte    (rd_byte),
    .ack_missing(ack_missing),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  i2cbe_bus_checker bus_chk (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd_valid      (cmd_valid),
    .func           (func),
    .wr_byte        (wr_byte),
    .sda_in         (sda_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .scl_out        (scl_out),
    .sda_out        (sda_out),
    .busy_res       (busy_res),
    .cmd_done       (cmd_done),
    .rd_byte        (rd_byte),
    .ack_missing    (ack_missing),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_pending(results_pending),
    .engine_busy    (engine_busy)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: stall pattern changes mode every so often, plus one long hold-off on request
  initial begin
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(negedge clk);
        if (squeeze_req) begin
          // hold off long enough that the engine fills and pushes back on the ticks
          squeeze_req = 1'b0;
          out_stall <= 1'b1;
          repeat (SQUEEZE_CYCLES) @(negedge clk);
        end
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // watchdog: ends the run once no transaction has moved for too long
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("[i2c_master_bit_engine_core] ERROR");
    $finish;
  end

  function automatic logic pick_sda(input sda_drive_t m);
    case (m)
      SDA_HIGH: return 1'b1;
      SDA_LOW: return 1'b0;
      SDA_SLOW_ACK: return ($urandom_range(0, 3) != 0);
      default: return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // one tick transaction; entered and left at a falling edge, bursts with random gaps
  task automatic send_tick(input logic cv, input logic [2:0] f, input logic [7:0] wb,
                           input logic s);
    int gap;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 600)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    cmd_valid <= cv;
    func <= f;
    wr_byte <= wb;
    sda_in <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
    ticks_sent++;
  endtask

  // offer a command to the idle engine, then keep ticking until it is idle again;
  // stray commands while busy (the done tick included) must be dropped
  task automatic run_cmd(input logic [2:0] f, input logic [7:0] b, input sda_drive_t m);
    if (ticks_sent >= tick_limit) return;
    send_tick(1'b1, f, b, pick_sda(m));
    while (engine_busy) begin
      if ($urandom_range(0, 7) == 0)
        send_tick(1'b1, 3'($urandom), 8'($urandom), pick_sda(m));
      else
        send_tick(1'b0, 3'($urandom), 8'($urandom), pick_sda(m));
    end
  endtask

  task automatic idle_ticks(input int n);
    repeat (n) send_tick(1'b0, 3'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // wait until every result is back, then give the pipeline a few cycles
  task automatic settle_engine();
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [i2cbe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [i2cbe_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // new setting, only with the engine idle and nothing in flight
  task automatic retune(input logic [15:0] ticks, input logic [7:0] limit);
    settle_engine();
    write_reg(i2cbe_pkg::CFG_PHASE_TICKS, ticks);
    write_reg(i2cbe_pkg::CFG_ACK_TIMEOUT, {8'd0, limit});
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // mostly well-formed transfers with random content, some noise
  task automatic run_transfer();
    int nbytes;
    int i;
    logic [7:0] addr;
    if ($urandom_range(0, 9) == 0) begin
      // noise: any code, unused one included, or bare ticks
      if ($urandom_range(0, 1) == 1)
        run_cmd(3'($urandom_range(0, 7)), 8'($urandom), SDA_COIN);
      else
        idle_ticks($urandom_range(1, 8));
    end else begin
      addr = 8'($urandom);
      run_cmd(i2cbe_pkg::OP_START, 8'($urandom), SDA_COIN);
      run_cmd(i2cbe_pkg::OP_WRITE, addr, SDA_COIN);
      if ($urandom_range(0, 7) == 0) begin
        // nobody answers: the engine gives up and stops the bus itself
        run_cmd(i2cbe_pkg::OP_WAIT, 8'($urandom), SDA_HIGH);
      end else begin
        run_cmd(i2cbe_pkg::OP_WAIT, 8'($urandom), SDA_SLOW_ACK);
        nbytes = $urandom_range(1, 4);
        for (i = 0; i < nbytes; i++) begin
          if (addr[0]) begin
            run_cmd(i2cbe_pkg::OP_READ, 8'($urandom), SDA_COIN);
            run_cmd((i == nbytes - 1) ? i2cbe_pkg::OP_NACK : i2cbe_pkg::OP_ACK,
                    8'($urandom), SDA_COIN);
          end else begin
            run_cmd(i2cbe_pkg::OP_WRITE, 8'($urandom), SDA_COIN);
            run_cmd(i2cbe_pkg::OP_WAIT, 8'($urandom), SDA_SLOW_ACK);
          end
        end
        // sometimes leave the bus held for a repeated start
        if ($urandom_range(0, 5) != 0) run_cmd(i2cbe_pkg::OP_STOP, 8'($urandom), SDA_COIN);
      end
      if ($urandom_range(0, 3) == 0) idle_ticks($urandom_range(1, 3));
    end
  endtask

  initial begin
    int setting;
    int rand_base;
    logic [15:0] ticks;
    logic [7:0] limit;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, reset settings: one step per tick, 200 polls allowed
    run_cmd(i2cbe_pkg::OP_START, 8'h00, SDA_COIN);
    run_cmd(i2cbe_pkg::OP_WRITE, 8'hFF, SDA_COIN);
    run_cmd(i2cbe_pkg::OP_WAIT, 8'h00, SDA_LOW);
    run_cmd(i2cbe_pkg::OP_WRITE, 8'h00, SDA_COIN);
    run_cmd(i2cbe_pkg::OP_WAIT, 8'hFF, SDA_SLOW_ACK);
    run_cmd(i2cbe_pkg::OP_WRITE, 8'hA5, SDA_COIN);
    // sda held high the whole time: timeout, stop sequence, ack_missing set
    run_cmd(i2cbe_pkg::OP_WAIT, 8'h5A, SDA_HIGH);
    run_cmd(i2cbe_pkg::OP_START, 8'h00, SDA_COIN);
    run_cmd(i2cbe_pkg::OP_READ, 8'h00, SDA_HIGH);
    run_cmd(i2cbe_pkg::OP_ACK, 8'h00, SDA_COIN);
    run_cmd(i2cbe_pkg::OP_READ, 8'hFF, SDA_LOW);
    run_cmd(i2cbe_pkg::OP_NACK, 8'h00, SDA_COIN);
    run_cmd(i2cbe_pkg::OP_READ, 8'h3C, SDA_COIN);
    run_cmd(i2cbe_pkg::OP_STOP, 8'h00, SDA_COIN);
    // unused code leaves the engine idle
    run_cmd(FUNC_UNUSED, 8'hFF, SDA_COIN);
    // a fresh wait-ack clears the flag
    run_cmd(i2cbe_pkg::OP_WAIT, 8'h00, SDA_LOW);
    idle_ticks(3);

    // zero hold acts as one, zero limit times out on the first high poll
    retune(16'd0, 8'd0);
    run_cmd(i2cbe_pkg::OP_START, 8'h00, SDA_COIN);
    run_cmd(i2cbe_pkg::OP_WRITE, 8'h96, SDA_COIN);
    run_cmd(i2cbe_pkg::OP_WAIT, 8'h00, SDA_HIGH);
    run_cmd(i2cbe_pkg::OP_WAIT, 8'h00, SDA_COIN);
    run_cmd(i2cbe_pkg::OP_STOP, 8'h00, SDA_COIN);

    // long hold; polling does not use the step timer
    retune(16'd24, 8'hFF);
    run_cmd(i2cbe_pkg::OP_WAIT, 8'h00, SDA_LOW);

    // random part under several settings, sharing what is left of the tick budget
    rand_base = ticks_sent;
    for (setting = 0; setting < NUM_SETTINGS; setting++) begin
      case (setting)
        0: begin
          ticks = 16'd1;
          limit = 8'd1;
        end
        1: begin
          ticks = 16'd3;
          limit = 8'd255;
        end
        default: begin
          ticks = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
          case ($urandom_range(0, 3))
            0: limit = 8'd0;
            1: limit = 8'd255;
            2: limit = 8'($urandom_range(1, 10));
            default: limit = 8'($urandom_range(0, 255));
          endcase
        end
      endcase
      retune(ticks, limit);
      if (setting == 2) squeeze_req = 1'b1;
      tick_limit = rand_base + ((ITEMS_TOTAL - rand_base) * (setting + 1)) / NUM_SETTINGS;
      while (ticks_sent < tick_limit) run_transfer();
    end

    // drain: every outstanding result, then a few more cycles for strays
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0)
      $display("[i2c_master_bit_engine_core] OK");
    else
      $display("[i2c_master_bit_engine_core] ERROR");
    $finish;
  end

endmodule
